>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sphere triangle subdivider.
// ----------------------------------------------------------------------------
package sts_pkg;

  // subdivision level bounds and reset value
  localparam int MAX_LEVEL = 3;
  localparam logic [1:0] LEVEL_RESET = 2'd1;

  // register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_LEVEL = 3'd0;

  // vertex pipeline: front end, square root stages, divider stages
  localparam int SQ_STG  = 8;
  localparam int DIV_STG = 4;
  localparam int LAT     = 5 + SQ_STG + 1 + DIV_STG + 1;

  // three packed 16 bit coordinates: x, y, z
  typedef logic [2:0][15:0] vec16_t;

  // grid weights of one vertex: apex, first corner, third corner
  typedef struct packed {
    logic [3:0] wb;
    logic [3:0] wa;
    logic [3:0] wc;
  } weight_t;

endpackage

>>> src/sts_in_if.sv
// ----------------------------------------------------------------------------
// sts_in_if
// Base triangle channel: three corners, Q2.13.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] corner_a_x;
  logic signed [15:0] corner_a_y;
  logic signed [15:0] corner_a_z;
  logic signed [15:0] corner_b_x;
  logic signed [15:0] corner_b_y;
  logic signed [15:0] corner_b_z;
  logic signed [15:0] corner_c_x;
  logic signed [15:0] corner_c_y;
  logic signed [15:0] corner_c_z;

  modport source (output valid, corner_a_x, corner_a_y, corner_a_z,
                  corner_b_x, corner_b_y, corner_b_z,
                  corner_c_x, corner_c_y, corner_c_z, input ready);
  modport sink (input valid, corner_a_x, corner_a_y, corner_a_z,
                corner_b_x, corner_b_y, corner_b_z,
                corner_c_x, corner_c_y, corner_c_z, output ready);
endinterface

>>> src/sts_out_if.sv
// ----------------------------------------------------------------------------
// sts_out_if
// Output triangle channel: three unit vertices, Q1.14, plus end marker.
// ----------------------------------------------------------------------------
interface sts_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] vertex_one_x;
  logic signed [15:0] vertex_one_y;
  logic signed [15:0] vertex_one_z;
  logic signed [15:0] vertex_two_x;
  logic signed [15:0] vertex_two_y;
  logic signed [15:0] vertex_two_z;
  logic signed [15:0] vertex_three_x;
  logic signed [15:0] vertex_three_y;
  logic signed [15:0] vertex_three_z;
  logic              last_of_run;

  modport source (output valid, vertex_one_x, vertex_one_y, vertex_one_z,
                  vertex_two_x, vertex_two_y, vertex_two_z,
                  vertex_three_x, vertex_three_y, vertex_three_z,
                  last_of_run, input ready);
  modport sink (input valid, vertex_one_x, vertex_one_y, vertex_one_z,
                vertex_two_x, vertex_two_y, vertex_two_z,
                vertex_three_x, vertex_three_y, vertex_three_z,
                last_of_run, output ready);
endinterface

>>> src/sts_vtx.sv
// ----------------------------------------------------------------------------
// sts_vtx
// One vertex lane: weighted corner sum, squared length, normalize,
// pipelined square root and pipelined division to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
module sts_vtx import sts_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  vec16_t  ca,
  input  vec16_t  cb,
  input  vec16_t  cc,
  input  weight_t w,
  output vec16_t  vout
);

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [15:0] q;
    logic [15:0] lo;
  } dv_t;

  // four digits of the square root
  function automatic sq_t sq_steps(sq_t x);
    sq_t y;
    logic [35:0] rn;
    logic [35:0] trial;
    y = x;
    for (int s = 0; s < 4; s++) begin
      rn = {y.rem[33:0], y.rad[63:62]};
      trial = {2'b00, y.root, 2'b01};
      if (rn >= trial) begin
        y.rem = rn - trial;
        y.root = {y.root[30:0], 1'b1};
      end else begin
        y.rem = rn;
        y.root = {y.root[30:0], 1'b0};
      end
      y.rad = {y.rad[61:0], 2'b00};
    end
    return y;
  endfunction

  // four quotient bits
  function automatic dv_t dv_steps(dv_t x, logic [31:0] d);
    dv_t y;
    logic [32:0] rn;
    y = x;
    for (int s = 0; s < 4; s++) begin
      rn = {y.rem[31:0], y.lo[15]};
      if (rn >= {1'b0, d}) begin
        y.rem = rn - {1'b0, d};
        y.q = {y.q[14:0], 1'b1};
      end else begin
        y.rem = rn;
        y.q = {y.q[14:0], 1'b0};
      end
      y.lo = {y.lo[14:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic signed [20:0] wmul(logic [3:0] k, logic [15:0] v);
    return $signed({1'b0, k}) * $signed(v);
  endfunction

  // stage 1: weighted sum N
  logic signed [19:0] n1 [3];
  logic signed [22:0] nsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nsum[c] = 23'(wmul(w.wb, cb[c])) + 23'(wmul(w.wa, ca[c]))
              + 23'(wmul(w.wc, cc[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) n1[c] <= nsum[c][19:0];
    end
  end

  // stage 2: magnitudes and squares
  logic [18:0] a2 [3];
  logic [37:0] sq2 [3];
  logic [2:0]  neg2;
  logic [18:0] mag [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = n1[c][19] ? 19'(-n1[c]) : n1[c][18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a2[c]   <= mag[c];
        neg2[c] <= n1[c][19];
        sq2[c]  <= 38'(mag[c] * mag[c]);
      end
    end
  end

  // stage 3: squared length
  logic [37:0] s3;
  logic [18:0] a3 [3];
  logic [2:0]  neg3;

  always_ff @(posedge clk) begin
    if (en) begin
      s3   <= sq2[0] + sq2[1] + sq2[2];
      a3   <= a2;
      neg3 <= neg2;
    end
  end

  // stage 4: normalizing shift amount
  logic [4:0]  k4;
  logic        zero4;
  logic [37:0] s4;
  logic [18:0] a4 [3];
  logic [2:0]  neg4;
  logic [5:0]  top;

  always_comb begin
    top = '0;
    for (int b = 0; b < 38; b++) begin
      if (s3[b]) top = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k4    <= 5'((7'd61 - 7'(top)) >> 1);
      zero4 <= (s3 == '0);
      s4    <= s3;
      a4    <= a3;
      neg4  <= neg3;
    end
  end

  // stage 5 and square root stages
  sq_t         sq  [SQ_STG+1];
  logic [30:0] as  [SQ_STG+1][3];
  logic [2:0]  sgn [SQ_STG+1];
  logic        zr  [SQ_STG+1];
  logic [63:0] snorm;
  logic [49:0] ashift [3];

  always_comb begin
    snorm = {26'b0, s4} << {k4, 1'b0};
    for (int c = 0; c < 3; c++) ashift[c] = {31'b0, a4[c]} << k4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].rad  <= snorm;
      for (int c = 0; c < 3; c++) as[0][c] <= ashift[c][30:0];
      sgn[0] <= neg4;
      zr[0]  <= zero4;
    end
  end

  for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq[g+1]  <= sq_steps(sq[g]);
        as[g+1]  <= as[g];
        sgn[g+1] <= sgn[g];
        zr[g+1]  <= zr[g];
      end
    end
  end

  // divider setup and stages
  dv_t         dv   [DIV_STG+1][3];
  logic [31:0] dd   [DIV_STG+1];
  logic [2:0]  dsgn [DIV_STG+1];
  logic        dzr  [DIV_STG+1];
  logic [47:0] num  [3];
  logic [31:0] m;

  always_comb begin
    m = sq[SQ_STG].root;
    for (int c = 0; c < 3; c++) begin
      num[c] = ({17'b0, as[SQ_STG][c]} << 15) + {16'b0, m};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dv[0][c].rem <= {1'b0, num[c][47:16]};
        dv[0][c].q   <= '0;
        dv[0][c].lo  <= num[c][15:0];
      end
      dd[0]   <= {m[30:0], 1'b0};
      dsgn[0] <= sgn[SQ_STG];
      dzr[0]  <= zr[SQ_STG];
    end
  end

  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) dv[g+1][c] <= dv_steps(dv[g][c], dd[g]);
        dd[g+1]   <= dd[g];
        dsgn[g+1] <= dsgn[g];
        dzr[g+1]  <= dzr[g];
      end
    end
  end

  // final: sign and zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (dzr[DIV_STG]) begin
          vout[c] <= '0;
        end else if (dsgn[DIV_STG][c]) begin
          vout[c] <= 16'(-dv[DIV_STG][c].q);
        end else begin
          vout[c] <= dv[DIV_STG][c].q;
        end
      end
    end
  end

endmodule

>>> src/sphere_triangle_subdivider.sv
// Throughput: one output triangle per cycle while issuing, unless the output
// stalls (triangles.ready low with a valid output); a base triangle holds the
// input while the strip sequencer issues its 4^n triangles, and the next base
// triangle can be taken only once the sequencer is idle again.
// Reset (rst, synchronous, active high) clears sequencer and valid bits and
// sets the level register to 1.
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// Geodesic subdivision of a base triangle into 4^n unit-sphere triangles.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider import sts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sts_in_if.sink             corners,
  sts_out_if.source          triangles,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration register
  logic [1:0] level;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LEVEL) ? {30'b0, level} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_LEVEL) begin
      level <= pwdata[1:0];
    end
  end

  // base triangle capture
  vec16_t     ca, cb, cc;
  logic       busy;
  logic [3:0] rows;
  logic       en;
  logic       take;

  assign corners.ready = !busy;
  assign take = corners.valid && !busy;

  always_ff @(posedge clk) begin
    if (take) begin
      ca <= {corners.corner_a_z, corners.corner_a_y, corners.corner_a_x};
      cb <= {corners.corner_b_z, corners.corner_b_y, corners.corner_b_x};
      cc <= {corners.corner_c_z, corners.corner_c_y, corners.corner_c_x};
      rows <= 4'(1) << ((level > 2'(MAX_LEVEL)) ? 2'(MAX_LEVEL) : level);
    end
  end

  // strip sequencer: row i, step j, odd/even triangle
  logic [2:0] ri, rj;
  logic       odd;
  logic       seq_last;
  logic       row_end;
  logic [3:0] i0, i1, j0, j1;

  assign row_end  = !odd && rj == ri;
  assign seq_last = row_end && (4'(ri) + 4'd1 == rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ri <= '0;
      rj <= '0;
      odd <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
      ri <= '0;
      rj <= '0;
      odd <= 1'b0;
    end else if (busy && en) begin
      if (seq_last) begin
        busy <= 1'b0;
      end else if (row_end) begin
        ri <= ri + 3'd1;
        rj <= '0;
      end else if (odd) begin
        odd <= 1'b0;
        rj <= rj + 3'd1;
      end else begin
        odd <= 1'b1;
      end
    end
  end

  // grid points of the current triangle
  weight_t w1, w2, w3;

  function automatic weight_t grid_w(logic [3:0] rr, logic [3:0] r, logic [3:0] j);
    weight_t x;
    x.wb = rr - r;
    x.wa = r - j;
    x.wc = j;
    return x;
  endfunction

  always_comb begin
    i0 = 4'(ri);
    i1 = 4'(ri) + 4'd1;
    j0 = 4'(rj);
    j1 = 4'(rj) + 4'd1;
    if (odd) begin
      w1 = grid_w(rows, i0, j1);
      w2 = grid_w(rows, i1, j1);
      w3 = grid_w(rows, i0, j0);
    end else begin
      w1 = grid_w(rows, i1, j0);
      w2 = grid_w(rows, i0, j0);
      w3 = grid_w(rows, i1, j1);
    end
  end

  // valid and end marker travel with the vertex pipelines
  logic [LAT-1:0] vld, lst;

  assign en = !vld[LAT-1] || triangles.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], busy};
    end
  end

  always_ff @(posedge clk) begin
    if (en) lst <= {lst[LAT-2:0], seq_last};
  end

  // three vertex lanes
  vec16_t p1, p2, p3;

  sts_vtx u_v1 (.clk(clk), .en(en), .ca(ca), .cb(cb), .cc(cc), .w(w1), .vout(p1));
  sts_vtx u_v2 (.clk(clk), .en(en), .ca(ca), .cb(cb), .cc(cc), .w(w2), .vout(p2));
  sts_vtx u_v3 (.clk(clk), .en(en), .ca(ca), .cb(cb), .cc(cc), .w(w3), .vout(p3));

  assign triangles.valid          = vld[LAT-1];
  assign triangles.last_of_run    = lst[LAT-1];
  assign triangles.vertex_one_x   = p1[0];
  assign triangles.vertex_one_y   = p1[1];
  assign triangles.vertex_one_z   = p1[2];
  assign triangles.vertex_two_x   = p2[0];
  assign triangles.vertex_two_y   = p2[1];
  assign triangles.vertex_two_z   = p2[2];
  assign triangles.vertex_three_x = p3[0];
  assign triangles.vertex_three_y = p3[1];
  assign triangles.vertex_three_z = p3[2];

  // checks
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy) else $error("sequencer not started");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    busy && en && seq_last |=> !busy) else $error("sequencer overran");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !corners.ready) else $error("input taken while busy");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    triangles.valid |-> ($signed(p1[0]) <= 16'sd16384 && $signed(p1[0]) >= -16'sd16384))
    else $error("vertex out of range");

endmodule
